>>> rtl/core/trqs_pkg.sv
// Shared types and codes for the thread ready-queue scheduler.
`default_nettype none
package trqs_pkg;

  typedef enum logic [3:0] {
    CMD_TICK    = 4'd0,
    CMD_YIELD   = 4'd1,
    CMD_BLOCK   = 4'd2,
    CMD_AWAKE   = 4'd3,
    CMD_CREATE  = 4'd4,
    CMD_KILL    = 4'd5,
    CMD_PROT_EN = 4'd6,
    CMD_PROT_EX = 4'd7,
    CMD_LOCK    = 4'd8,
    CMD_UNLOCK  = 4'd9
  } cmd_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FREE   = 3'd1;
  localparam logic [2:0] ST_NOT_BLK   = 3'd2;
  localparam logic [2:0] ST_DEFERRED  = 3'd3;
  localparam logic [2:0] ST_BAD_TGT   = 3'd4;
  localparam logic [2:0] ST_NOT_LOCKR = 3'd5;

  // Thread states
  localparam logic [1:0] TS_FREE    = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;
  localparam logic [1:0] TS_BLOCKED = 2'd3;

  localparam logic [3:0] YIELD_LIMIT_RESET = 4'd3;
  localparam logic [3:0] YIELD_SAT         = 4'd15;

  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] target;
    logic       with_semaphore;
  } in_item_t;

  typedef struct packed {
    logic [3:0] running;
    logic [3:0] previous;
    logic [3:0] new_thread;
    logic [2:0] status;
    logic       released_valid;
    logic [3:0] released_thread;
    logic       sem_release;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/thread_ready_queue_scheduler.sv
// Top level: thread scheduler with linked ready queue held in link memories.
// A command is accepted on start while idle and runs decode, unlink, reschedule and append states.
// A new command is taken only once the last result is out (busy low); link reads are registered.
// Killing another slot adds an unlink; a reschedule adds an append and an unlink of the pick.
// The receiver cannot stall; the result is shown one cycle under out_valid.
// Reset (synchronous, active low): slot 1 running, slot 0 ready, queue empty.
`default_nettype none
module thread_ready_queue_scheduler #(
  parameter int PROTECT_BITS = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire trqs_pkg::in_item_t in_item,
  output logic                   out_valid,
  output trqs_pkg::out_item_t    out_item,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [3:0]              cfg_data
);

  localparam int NS = 16;
  localparam logic [PROTECT_BITS-1:0] PMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RM_RD, S_RM_WR, S_RS, S_HD_RD, S_HD_WR, S_PUSH, S_DONE
  } state_t;

  // Per-slot state in flip-flops (each with its own reset value)
  logic [1:0]              tstat_r [NS];
  logic                    inq_r   [NS];
  logic                    semw_r  [NS];
  logic                    kpend_r [NS];
  logic [PROTECT_BITS-1:0] pdep_r  [NS];

  // Link memories: one read and one write per cycle
  logic [3:0] qnext_mem [NS];
  logic [3:0] qprev_mem [NS];
  logic [3:0] rd_next_r, rd_prev_r;
  logic [3:0] rd_addr;
  logic       nx_we, pv_we;
  logic [3:0] nx_wa, nx_wd, pv_wa, pv_wd;

  state_t               state_r;
  trqs_pkg::in_item_t   it_r;
  logic [3:0] head_r, tail_r, cur_r, locker_r, yrun_r, ylim_r;
  logic [4:0] qcnt_r;
  logic       lockv_r;
  // Work registers
  logic [3:0] rm_r, nxt_r, kill_r, pushs_r, newt_r, prev_r;
  logic       do_rs_r, byy_r, kill_v_r, sem_r, pushq_r;
  logic [2:0] status_r;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // Lowest free slot above idle
  logic [3:0] free_s;
  logic       free_v;
  always_comb begin
    free_s = '0;
    free_v = 1'b0;
    for (int i = NS - 1; i >= 1; i--) begin
      if (tstat_r[i] == trqs_pkg::TS_FREE) begin
        free_s = 4'(i);
        free_v = 1'b1;
      end
    end
  end

  // Both unlink reads address the slot being removed
  assign rd_addr = rm_r;

  always_ff @(posedge clk) begin
    rd_next_r <= qnext_mem[rd_addr];
    rd_prev_r <= qprev_mem[rd_addr];
    if (nx_we) qnext_mem[nx_wa] <= nx_wd;
    if (pv_we) qprev_mem[pv_wa] <= pv_wd;
  end

  // Link writes: removal unlink in S_RM_WR/S_HD_WR, append in S_PUSH
  always_comb begin
    nx_we = 1'b0; pv_we = 1'b0;
    nx_wa = '0; nx_wd = '0; pv_wa = '0; pv_wd = '0;
    unique case (state_r)
      S_RM_WR, S_HD_WR: begin
        nx_wa = rd_prev_r; nx_wd = rd_next_r;
        pv_wa = rd_next_r; pv_wd = rd_prev_r;
        nx_we = inq_r[rm_r] && (rm_r != head_r);
        pv_we = inq_r[rm_r] && (rm_r != tail_r);
      end
      S_PUSH: begin
        pv_we = pushq_r && !inq_r[pushs_r] && (pushs_r != '0);
        pv_wa = pushs_r; pv_wd = tail_r;
        nx_we = pv_we && (qcnt_r != '0);
        nx_wa = tail_r; nx_wd = pushs_r;
      end
      default: ;
    endcase
  end

  // Control: decode, unlink, reschedule, append, report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      head_r <= '0; tail_r <= '0; qcnt_r <= '0;
      cur_r <= 4'd1; lockv_r <= 1'b0; locker_r <= '0; yrun_r <= '0;
      ylim_r <= trqs_pkg::YIELD_LIMIT_RESET;
      for (int i = 0; i < NS; i++) begin
        tstat_r[i] <= (i == 0) ? trqs_pkg::TS_READY :
                      (i == 1) ? trqs_pkg::TS_RUNNING : trqs_pkg::TS_FREE;
        inq_r[i] <= 1'b0; semw_r[i] <= 1'b0; kpend_r[i] <= 1'b0; pdep_r[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) ylim_r <= cfg_data;
          if (start) begin
            it_r <= in_item;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          prev_r <= cur_r; newt_r <= '0; status_r <= trqs_pkg::ST_OK;
          kill_v_r <= 1'b0; sem_r <= 1'b0; do_rs_r <= 1'b0; byy_r <= 1'b0;
          pushq_r <= 1'b0; kill_r <= '0; rm_r <= '0;
          state_r <= S_DONE;
          unique case (it_r.cmd)
            trqs_pkg::CMD_TICK: begin do_rs_r <= 1'b1; state_r <= S_RS; end
            trqs_pkg::CMD_YIELD: begin
              do_rs_r <= 1'b1; byy_r <= 1'b1; state_r <= S_RS;
            end
            trqs_pkg::CMD_BLOCK: begin
              if (cur_r == '0) status_r <= trqs_pkg::ST_BAD_TGT;
              else begin
                tstat_r[cur_r] <= trqs_pkg::TS_BLOCKED;
                semw_r[cur_r] <= it_r.with_semaphore;
                state_r <= S_RS;
              end
            end
            trqs_pkg::CMD_AWAKE: begin
              if (tstat_r[it_r.target] != trqs_pkg::TS_BLOCKED)
                status_r <= trqs_pkg::ST_NOT_BLK;
              else begin
                tstat_r[it_r.target] <= trqs_pkg::TS_READY;
                semw_r[it_r.target] <= 1'b0;
                pushq_r <= 1'b1; pushs_r <= it_r.target; state_r <= S_PUSH;
              end
            end
            trqs_pkg::CMD_CREATE: begin
              if (!free_v) status_r <= trqs_pkg::ST_NO_FREE;
              else begin
                tstat_r[free_s] <= trqs_pkg::TS_READY;
                semw_r[free_s] <= 1'b0; pdep_r[free_s] <= '0; kpend_r[free_s] <= 1'b0;
                newt_r <= free_s;
                pushq_r <= 1'b1; pushs_r <= free_s; state_r <= S_PUSH;
              end
            end
            trqs_pkg::CMD_KILL: begin
              if (it_r.target == '0 || tstat_r[it_r.target] == trqs_pkg::TS_FREE)
                status_r <= trqs_pkg::ST_BAD_TGT;
              else if (pdep_r[it_r.target] != '0) begin
                kpend_r[it_r.target] <= 1'b1; status_r <= trqs_pkg::ST_DEFERRED;
              end else begin
                kill_v_r <= 1'b1; kill_r <= it_r.target;
                sem_r <= semw_r[it_r.target];
                if (it_r.target == cur_r) state_r <= S_RS;
                else begin rm_r <= it_r.target; state_r <= S_RM_RD; end
              end
            end
            trqs_pkg::CMD_PROT_EN: begin
              if (kpend_r[cur_r]) begin
                kill_v_r <= 1'b1; kill_r <= cur_r; sem_r <= semw_r[cur_r];
                state_r <= S_RS;
              end else if (pdep_r[cur_r] != PMAX)
                pdep_r[cur_r] <= pdep_r[cur_r] + 1'b1;
            end
            trqs_pkg::CMD_PROT_EX: begin
              if (pdep_r[cur_r] != '0) begin
                pdep_r[cur_r] <= pdep_r[cur_r] - 1'b1;
                if (pdep_r[cur_r] == PROTECT_BITS'(1) && kpend_r[cur_r]) begin
                  kill_v_r <= 1'b1; kill_r <= cur_r; sem_r <= semw_r[cur_r];
                  state_r <= S_RS;
                end
              end
            end
            trqs_pkg::CMD_LOCK: begin lockv_r <= 1'b1; locker_r <= cur_r; end
            trqs_pkg::CMD_UNLOCK: begin
              if (lockv_r && locker_r == cur_r) begin
                lockv_r <= 1'b0; locker_r <= '0;
              end else status_r <= trqs_pkg::ST_NOT_LOCKR;
            end
            default: ;
          endcase
        end
        // Wait for the registered read of the removed slot's links
        S_RM_RD: state_r <= S_RM_WR;
        S_RM_WR, S_HD_WR: begin
          if (inq_r[rm_r]) begin
            if (rm_r == head_r) head_r <= rd_next_r;
            if (rm_r == tail_r) tail_r <= rd_prev_r;
            inq_r[rm_r] <= 1'b0;
            qcnt_r <= qcnt_r - 1'b1;
          end
          state_r <= S_DONE;
        end
        // Requeue current if running, then pick next
        S_RS: begin
          logic [4:0] cnt;
          logic [3:0] yr, hd, pick;
          logic       rmv, cur_run;
          cnt = qcnt_r; hd = head_r;
          pick = '0; rmv = 1'b0;
          // A thread being killed is never requeued
          cur_run = (tstat_r[cur_r] == trqs_pkg::TS_RUNNING) && !kill_v_r;
          if (cur_run && cur_r != '0 && !inq_r[cur_r]) begin
            if (cnt == '0) hd = cur_r;
            cnt = cnt + 1'b1;
          end
          yr = byy_r ? ((yrun_r != trqs_pkg::YIELD_SAT) ? yrun_r + 1'b1 : yrun_r) : '0;
          if (lockv_r) begin
            if (tstat_r[locker_r] == trqs_pkg::TS_READY ||
                (cur_run && locker_r == cur_r)) begin
              pick = locker_r; rmv = 1'b1;
            end
          end else if (cnt == '0) pick = '0;
          else if (yr > ylim_r) yr = '0;
          else begin pick = hd; rmv = 1'b1; end
          yrun_r <= yr;
          // Mark states now; the append and the unlink follow in later cycles
          if (kill_v_r) tstat_r[kill_r] <= trqs_pkg::TS_FREE;
          else if (cur_run) tstat_r[cur_r] <= trqs_pkg::TS_READY;
          nxt_r <= pick; rm_r <= pick;
          do_rs_r <= rmv;
          pushq_r <= cur_run && cur_r != '0;
          pushs_r <= cur_r;
          state_r <= S_PUSH;
        end
        // Append a slot at the tail; after a reschedule, also make the pick the running thread
        S_PUSH: begin
          if (pushq_r && !inq_r[pushs_r] && pushs_r != '0) begin
            if (qcnt_r == '0) head_r <= pushs_r;
            tail_r <= pushs_r; inq_r[pushs_r] <= 1'b1; qcnt_r <= qcnt_r + 1'b1;
          end
          pushq_r <= 1'b0;
          if (it_r.cmd == trqs_pkg::CMD_AWAKE || it_r.cmd == trqs_pkg::CMD_CREATE)
            state_r <= S_DONE;
          else begin
            tstat_r[nxt_r] <= trqs_pkg::TS_RUNNING;
            cur_r <= nxt_r;
            state_r <= do_rs_r ? S_HD_RD : S_DONE;
          end
        end
        S_HD_RD: state_r <= S_HD_WR;
        S_DONE: begin
          if (kill_v_r) begin
            semw_r[kill_r] <= 1'b0; pdep_r[kill_r] <= '0; kpend_r[kill_r] <= 1'b0;
            tstat_r[kill_r] <= trqs_pkg::TS_FREE;
            if (lockv_r && locker_r == kill_r) begin
              lockv_r <= 1'b0; locker_r <= '0;
            end
          end
          out_item.running         <= cur_r;
          out_item.previous        <= prev_r;
          out_item.new_thread      <= newt_r;
          out_item.status          <= status_r;
          out_item.released_valid  <= kill_v_r;
          out_item.released_thread <= kill_r;
          out_item.sem_release     <= sem_r;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 5'(NS - 1)) else $error("queue count overflow");
  a_idle_q: assert property (@(posedge clk) disable iff (!rst_n)
    !inq_r[0]) else $error("idle slot queued");
  a_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.released_valid |-> out_item.released_thread != '0)
    else $error("idle released");
`endif

endmodule
`default_nettype wire

>>> dv/thread_ready_queue_scheduler_tb.sv
// Testbench for the thread ready-queue scheduler: directed and random commands checked
// against an in-bench scheduler model.
`default_nettype none
module thread_ready_queue_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int PROT_MAX = 255;
  localparam int STALL_LIMIT = 2000;
  localparam logic [2:0] TS_GONE = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  trqs_pkg::in_item_t in_item = '0;
  logic out_valid;
  trqs_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  thread_ready_queue_scheduler uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Scheduler state mirror
  logic [3:0] yield_limit;
  logic [2:0] tstat [SLOTS];
  logic [3:0] qnext [SLOTS];
  logic [3:0] qprev [SLOTS];
  logic       queued [SLOTS];
  logic [3:0] qhead, qtail;
  int         qcount;
  logic       semw [SLOTS];
  int         pdepth [SLOTS];
  logic       killp [SLOTS];
  logic [3:0] cur;
  logic       lock_v;
  logic [3:0] lock_s;
  int         yrun;

  trqs_pkg::out_item_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  function automatic void sched_reset();
    yield_limit = trqs_pkg::YIELD_LIMIT_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tstat[i] = trqs_pkg::TS_FREE; qnext[i] = 0; qprev[i] = 0; queued[i] = 0;
      semw[i] = 0; pdepth[i] = 0; killp[i] = 0;
    end
    tstat[0] = trqs_pkg::TS_READY;
    tstat[1] = trqs_pkg::TS_RUNNING;
    qhead = 0; qtail = 0; qcount = 0; cur = 1;
    lock_v = 0; lock_s = 0; yrun = 0;
  endfunction

  function automatic void q_append(logic [3:0] s);
    if (queued[s] || s == 0) return;
    qprev[s] = qtail;
    if (qcount == 0) qhead = s;
    else qnext[qtail] = s;
    qtail = s;
    queued[s] = 1;
    qcount++;
  endfunction

  function automatic void q_unlink(logic [3:0] s);
    if (!queued[s]) return;
    if (s == qhead) qhead = qnext[s];
    else qnext[qprev[s]] = qnext[s];
    if (s == qtail) qtail = qprev[s];
    else qprev[qnext[s]] = qprev[s];
    queued[s] = 0;
    qcount--;
  endfunction

  function automatic void pick_next(logic by_yield);
    logic [3:0] nxt;
    if (tstat[cur] == trqs_pkg::TS_RUNNING) begin
      if (cur != 0) q_append(cur);
      tstat[cur] = trqs_pkg::TS_READY;
    end
    if (by_yield) begin
      if (yrun < 15) yrun++;
    end else yrun = 0;
    if (lock_v) begin
      if (tstat[lock_s] == trqs_pkg::TS_READY) begin
        nxt = lock_s; q_unlink(lock_s);
      end else nxt = 0;
    end else if (qcount == 0) nxt = 0;
    else if (yrun > yield_limit) begin
      nxt = 0; yrun = 0;
    end else begin
      nxt = qhead; q_unlink(nxt);
    end
    tstat[nxt] = trqs_pkg::TS_RUNNING;
    cur = nxt;
  endfunction

  function automatic logic retire_slot(logic [3:0] s);
    logic sem;
    sem = semw[s];
    if (s == cur) begin
      tstat[s] = TS_GONE;
      pick_next(1'b0);
    end else q_unlink(s);
    tstat[s] = trqs_pkg::TS_FREE; semw[s] = 0; pdepth[s] = 0; killp[s] = 0;
    if (lock_v && lock_s == s) begin
      lock_v = 0; lock_s = 0;
    end
    return sem;
  endfunction

  function automatic trqs_pkg::out_item_t predict_schedule(trqs_pkg::in_item_t it);
    trqs_pkg::out_item_t r;
    logic [3:0] p;
    logic [3:0] t;
    r = '0;
    p = cur;
    t = it.target;
    r.previous = p;
    case (it.cmd)
      trqs_pkg::CMD_TICK:  pick_next(1'b0);
      trqs_pkg::CMD_YIELD: pick_next(1'b1);
      trqs_pkg::CMD_BLOCK: begin
        if (p == 0) r.status = trqs_pkg::ST_BAD_TGT;
        else begin
          tstat[p] = trqs_pkg::TS_BLOCKED; semw[p] = it.with_semaphore; pick_next(1'b0);
        end
      end
      trqs_pkg::CMD_AWAKE: begin
        if (tstat[t] != trqs_pkg::TS_BLOCKED) r.status = trqs_pkg::ST_NOT_BLK;
        else begin
          tstat[t] = trqs_pkg::TS_READY; semw[t] = 0; q_append(t);
        end
      end
      trqs_pkg::CMD_CREATE: begin
        r.status = trqs_pkg::ST_NO_FREE;
        for (int i = 1; i < SLOTS; i++) begin
          if (r.status == trqs_pkg::ST_NO_FREE && tstat[i] == trqs_pkg::TS_FREE) begin
            tstat[i] = trqs_pkg::TS_READY; semw[i] = 0; pdepth[i] = 0; killp[i] = 0;
            q_append(i[3:0]);
            r.new_thread = i[3:0];
            r.status = trqs_pkg::ST_OK;
          end
        end
      end
      trqs_pkg::CMD_KILL: begin
        if (t == 0 || tstat[t] == trqs_pkg::TS_FREE) r.status = trqs_pkg::ST_BAD_TGT;
        else if (pdepth[t] != 0) begin
          killp[t] = 1; r.status = trqs_pkg::ST_DEFERRED;
        end else begin
          r.sem_release = retire_slot(t); r.released_valid = 1; r.released_thread = t;
        end
      end
      trqs_pkg::CMD_PROT_EN: begin
        if (killp[p]) begin
          r.sem_release = retire_slot(p); r.released_valid = 1; r.released_thread = p;
        end else if (pdepth[p] < PROT_MAX) pdepth[p]++;
      end
      trqs_pkg::CMD_PROT_EX: begin
        if (pdepth[p] != 0) begin
          pdepth[p]--;
          if (pdepth[p] == 0 && killp[p]) begin
            r.sem_release = retire_slot(p); r.released_valid = 1; r.released_thread = p;
          end
        end
      end
      trqs_pkg::CMD_LOCK: begin
        lock_v = 1; lock_s = p;
      end
      trqs_pkg::CMD_UNLOCK: begin
        if (lock_v && lock_s == p) begin
          lock_v = 0; lock_s = 0;
        end else r.status = trqs_pkg::ST_NOT_LOCKR;
      end
      default: ;
    endcase
    r.running = cur;
    return r;
  endfunction

  // Check each result strobe against the oldest expectation
  always @(posedge clk) begin
    trqs_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_item.running !== e.running)
          report_mismatch("running", out_item.running, e.running);
        if (out_item.previous !== e.previous)
          report_mismatch("previous", out_item.previous, e.previous);
        if (out_item.new_thread !== e.new_thread)
          report_mismatch("new_thread", out_item.new_thread, e.new_thread);
        if (out_item.status !== e.status)
          report_mismatch("status", out_item.status, e.status);
        if (out_item.released_valid !== e.released_valid)
          report_mismatch("released_valid", out_item.released_valid, e.released_valid);
        if (out_item.released_thread !== e.released_thread)
          report_mismatch("released_thread", out_item.released_thread, e.released_thread);
        if (out_item.sem_release !== e.sem_release)
          report_mismatch("sem_release", out_item.sem_release, e.sem_release);
      end
    end
  end

  // Watchdog: count cycles with no handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog timeout at %0t", $realtime);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one command; hold start until accepted, leave it up for the next item
  task automatic send_cmd(input logic [3:0] c, input logic [3:0] t, input logic ws);
    trqs_pkg::in_item_t it;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    it.cmd = c; it.target = t; it.with_semaphore = ws;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_schedule(it));
  endtask

  // Drop start and wait for every expected result
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_yield_limit(input logic [3:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    yield_limit = v;
  endtask

  // Directed: every command and the named corner cases
  task automatic test_directed();
    send_cmd(trqs_pkg::CMD_UNLOCK, 0, 0);       // unlock by non-locker
    send_cmd(trqs_pkg::CMD_PROT_EX, 0, 0);      // exit at depth zero
    send_cmd(trqs_pkg::CMD_AWAKE, 4'd15, 0);    // not blocked
    send_cmd(trqs_pkg::CMD_KILL, 0, 0);         // kill idle
    send_cmd(trqs_pkg::CMD_KILL, 4'd9, 0);      // kill free slot
    send_cmd(trqs_pkg::CMD_CREATE, 0, 0);
    send_cmd(trqs_pkg::CMD_CREATE, 0, 0);
    send_cmd(trqs_pkg::CMD_YIELD, 0, 0);
    send_cmd(trqs_pkg::CMD_BLOCK, 0, 1);
    send_cmd(trqs_pkg::CMD_AWAKE, 4'd1, 0);
    send_cmd(trqs_pkg::CMD_PROT_EN, 0, 0);
    send_cmd(trqs_pkg::CMD_TICK, 0, 0);
    send_cmd(trqs_pkg::CMD_KILL, 4'd3, 0);      // deferred
    send_cmd(trqs_pkg::CMD_LOCK, 0, 0);
    send_cmd(trqs_pkg::CMD_TICK, 0, 0);
    send_cmd(trqs_pkg::CMD_UNLOCK, 0, 0);
    send_cmd(4'd10, 4'd5, 1);                   // unknown command
    send_cmd(4'd15, 4'd10, 0);
    for (int i = 0; i < 4; i++) send_cmd(trqs_pkg::CMD_TICK, 0, 0);
    send_cmd(trqs_pkg::CMD_BLOCK, 0, 0);
    drain();
  endtask

  // Fill the table to hit no-free-slot, then kill most slots
  task automatic test_full_table();
    for (int i = 0; i < 16; i++) send_cmd(trqs_pkg::CMD_CREATE, 0, 0);
    for (int i = 2; i < 16; i++) send_cmd(trqs_pkg::CMD_KILL, i[3:0], 0);
    drain();
  endtask

  // Random command mix, biased toward meaningful sequences
  task automatic test_random(input int n, input int pct);
    logic [3:0] c, t;
    int k;
    send_idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99, 0);
      if (k < 12) c = trqs_pkg::CMD_TICK;
      else if (k < 24) c = trqs_pkg::CMD_YIELD;
      else if (k < 34) c = trqs_pkg::CMD_BLOCK;
      else if (k < 46) c = trqs_pkg::CMD_AWAKE;
      else if (k < 58) c = trqs_pkg::CMD_CREATE;
      else if (k < 68) c = trqs_pkg::CMD_KILL;
      else if (k < 78) c = trqs_pkg::CMD_PROT_EN;
      else if (k < 86) c = trqs_pkg::CMD_PROT_EX;
      else if (k < 91) c = trqs_pkg::CMD_LOCK;
      else if (k < 97) c = trqs_pkg::CMD_UNLOCK;
      else c = 4'($urandom_range(15, 10));
      t = 4'($urandom_range(15, 0));
      if ((c == trqs_pkg::CMD_AWAKE || c == trqs_pkg::CMD_KILL) && $urandom_range(1, 0)) begin
        for (int s = 0; s < SLOTS; s++)
          if ((c == trqs_pkg::CMD_AWAKE && tstat[s] == trqs_pkg::TS_BLOCKED) ||
              (c == trqs_pkg::CMD_KILL && s != 0 && tstat[s] != trqs_pkg::TS_FREE &&
               $urandom_range(1, 0)))
            t = s[3:0];
      end
      send_cmd(c, t, 1'($urandom_range(1, 0)));
      if (i == n / 2) drain();   // pause until every result is in
    end
    send_idle_pct = 0;
    drain();
  endtask

  initial begin
    sched_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    write_yield_limit(4'd0);
    test_random(150, 0);
    write_yield_limit(4'd15);
    test_random(150, 53);
    write_yield_limit(4'd7);
    test_random(150, 10);
    write_yield_limit(4'd2);
    test_random(150, 0);
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
rtl/core/trqs_pkg.sv
rtl/core/thread_ready_queue_scheduler.sv
dv/thread_ready_queue_scheduler_tb.sv
